// File: sv/cwsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cwsa_pkg;
   localparam int DataWidth = 64;
   localparam int CmdWidth = 5;
   localparam int KindWidth = 3;
   localparam int StatusWidth = 2;
   localparam int DivStages = 16;
   localparam int DivBitsPerStage = DataWidth / DivStages;

   typedef enum logic [4:0] {
      CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_MUL = 5'd2, CMD_DIV = 5'd3, CMD_MOD = 5'd4,
      CMD_WADD = 5'd5, CMD_WSUB = 5'd6, CMD_WMUL = 5'd7,
      CMD_SADD = 5'd8, CMD_SSUB = 5'd9, CMD_SMUL = 5'd10,
      CMD_AND = 5'd11, CMD_OR = 5'd12, CMD_XOR = 5'd13, CMD_SHL = 5'd14, CMD_SHR = 5'd15,
      CMD_EQ = 5'd16, CMD_NE = 5'd17, CMD_LT = 5'd18, CMD_LE = 5'd19, CMD_GT = 5'd20,
      CMD_GE = 5'd21, CMD_NEG = 5'd22, CMD_BNOT = 5'd23, CMD_LNOT = 5'd24,
      CMD_CAST = 5'd25
   } cmd_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OVF = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   function automatic logic [63:0] width_mask(input logic [2:0] k);
      case (k[1:0])
         2'd0: width_mask = 64'h0000_0000_0000_00ff;
         2'd1: width_mask = 64'h0000_0000_0000_ffff;
         2'd2: width_mask = 64'h0000_0000_ffff_ffff;
         default: width_mask = '1;
      endcase
   endfunction

   function automatic logic [63:0] load_kind(input logic [2:0] k, input logic [63:0] v);
      logic [63:0] m;
      logic sb;
      m = width_mask(k);
      case (k[1:0])
         2'd0: sb = v[7];
         2'd1: sb = v[15];
         2'd2: sb = v[31];
         default: sb = v[63];
      endcase
      load_kind = (v & m) | ((!k[2] && sb) ? ~m : 64'd0);
   endfunction
endpackage
`default_nettype wire

// File: sv/checked_wrap_sat_integer_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// integer alu for signed/unsigned 8/16/32/64 bit kinds
// request channel: drive req_* with start high; the request is taken when busy
// is low. busy stays low here, so one request can be issued every cycle.
// result channel: rsp_valid is high for one cycle with rsp_result_value and
// rsp_status; the receiver must take it then and cannot stall.
// every request passes through the same stages no matter the operation, so
// results stay in request order. the pipe length is set by the restoring
// divider, 4 quotient bits per stage, 16 stages; the multiplier uses four
// 32x32 partial products in its own stages and is padded to the same length.
// throughput: one request per cycle.
// reset clears all valid bits in the pipe; no result follows a reset until a
// new request enters.
module checked_wrap_sat_integer_alu #(
   parameter int DIV_STAGES = cwsa_pkg::DivStages
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [cwsa_pkg::CmdWidth-1:0] req_cmd,
   input  wire logic [cwsa_pkg::KindWidth-1:0] req_kind,
   input  wire logic [cwsa_pkg::KindWidth-1:0] req_target_kind,
   input  wire logic [cwsa_pkg::DataWidth-1:0] req_operand_a,
   input  wire logic [cwsa_pkg::DataWidth-1:0] req_operand_b,
   output logic rsp_valid,
   output logic [cwsa_pkg::DataWidth-1:0] rsp_result_value,
   output logic [cwsa_pkg::StatusWidth-1:0] rsp_status
);
   import cwsa_pkg::*;

   localparam int Bps = DataWidth / DIV_STAGES;
   localparam int Depth = DIV_STAGES + 1;

   typedef struct packed {
      logic [4:0] cmd;
      logic [2:0] kind;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] r;
      logic [1:0] st;
      logic fin;
   } ctl_type;

   assign busy = 1'b0;

   // ---------------- stage 0: load and simple ops
   ctl_type s0_in;
   logic s0_v_ff;
   ctl_type s0_ff;
   logic [63:0] m0, a0, b0, wa, wb, sh0;
   logic [6:0] bits0;
   logic sg0;

   always_comb begin
      s0_in = '0;
      m0 = width_mask(req_kind);
      sg0 = !req_kind[2];
      bits0 = 7'd8 << req_kind[1:0];
      a0 = load_kind(req_kind, req_operand_a);
      b0 = load_kind(req_kind, req_operand_b);
      sh0 = req_operand_b & m0;
      wa = a0 + b0;
      wb = a0 - b0;
      s0_in.cmd = req_cmd;
      s0_in.kind = req_kind;
      s0_in.a = a0;
      s0_in.b = b0;
      s0_in.fin = 1'b1;
      case (req_cmd)
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_SADD, CMD_SSUB, CMD_SMUL, CMD_WMUL,
         CMD_DIV, CMD_MOD: s0_in.fin = 1'b0;
         CMD_WADD: s0_in.r = load_kind(req_kind, wa);
         CMD_WSUB: s0_in.r = load_kind(req_kind, wb);
         CMD_AND: s0_in.r = a0 & b0;
         CMD_OR: s0_in.r = a0 | b0;
         CMD_XOR: s0_in.r = a0 ^ b0;
         CMD_SHL, CMD_SHR: begin
            if (sh0 >= {57'd0, bits0}) s0_in.st = ST_OVF;
            else if (req_cmd == CMD_SHL)
               s0_in.r = load_kind(req_kind, (a0 & m0) << sh0[5:0]);
            else if (sg0) s0_in.r = $unsigned($signed(a0) >>> sh0[5:0]);
            else s0_in.r = a0 >> sh0[5:0];
         end
         CMD_EQ: s0_in.r = {63'd0, a0 == b0};
         CMD_NE: s0_in.r = {63'd0, a0 != b0};
         CMD_LT, CMD_LE, CMD_GT, CMD_GE: begin
            wa = sg0 ? {~a0[63], a0[62:0]} : a0;
            wb = sg0 ? {~b0[63], b0[62:0]} : b0;
            case (req_cmd)
               CMD_LT: s0_in.r = {63'd0, wa < wb};
               CMD_LE: s0_in.r = {63'd0, wa <= wb};
               CMD_GT: s0_in.r = {63'd0, wa > wb};
               default: s0_in.r = {63'd0, wa >= wb};
            endcase
         end
         CMD_NEG: begin
            if (sg0) begin
               if (a0 == ~(m0 >> 1)) s0_in.st = ST_OVF;
               else s0_in.r = 64'd0 - a0;
            end else if (a0 != 64'd0) s0_in.st = ST_OVF;
         end
         CMD_BNOT: s0_in.r = load_kind(req_kind, ~a0);
         CMD_LNOT: s0_in.r = {63'd0, !req_operand_a[0]};
         CMD_CAST: s0_in.r = load_kind(req_target_kind, a0);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s0_v_ff <= 1'b0;
      else s0_v_ff <= start && !busy;
      s0_ff <= s0_in;
   end

   // ---------------- stage 1: add/sub checks, mul partials, divider setup
   ctl_type s1_in;
   logic [63:0] m1, smax1, smin1, ra, rs, ua, ub;
   logic ov;
   logic [63:0] p_ll_in, p_lh_in, p_hl_in, p_hh_in;
   logic [63:0] dq_in, dr_in;

   always_comb begin
      s1_in = s0_ff;
      m1 = width_mask(s0_ff.kind);
      smax1 = m1 >> 1;
      smin1 = ~(m1 >> 1);
      ra = s0_ff.a + s0_ff.b;
      rs = s0_ff.a - s0_ff.b;
      ov = 1'b0;
      ua = (s0_ff.a[63] && !s0_ff.kind[2]) ? 64'd0 - s0_ff.a : s0_ff.a;
      ub = (s0_ff.b[63] && !s0_ff.kind[2]) ? 64'd0 - s0_ff.b : s0_ff.b;
      p_ll_in = 64'(s0_ff.a[31:0]) * 64'(s0_ff.b[31:0]);
      p_lh_in = 64'(s0_ff.a[31:0]) * 64'(s0_ff.b[63:32]);
      p_hl_in = 64'(s0_ff.a[63:32]) * 64'(s0_ff.b[31:0]);
      p_hh_in = 64'(s0_ff.a[63:32]) * 64'(s0_ff.b[63:32]);
      dq_in = s0_ff.kind[2] ? s0_ff.a : ua;
      dr_in = s0_ff.kind[2] ? s0_ff.b : ub;
      case (s0_ff.cmd)
         CMD_ADD, CMD_SADD, CMD_SUB, CMD_SSUB: begin
            if (s0_ff.cmd == CMD_ADD || s0_ff.cmd == CMD_SADD) begin
               s1_in.r = ra;
               if (!s0_ff.kind[2])
                  ov = ((s0_ff.a ^ ra) & (s0_ff.b ^ ra)) >> 63 != 64'd0
                     || load_kind(s0_ff.kind, ra) != ra;
               else ov = ra < s0_ff.a || ra > m1;
            end else begin
               s1_in.r = rs;
               if (!s0_ff.kind[2])
                  ov = ((s0_ff.a ^ s0_ff.b) & (s0_ff.a ^ rs)) >> 63 != 64'd0
                     || load_kind(s0_ff.kind, rs) != rs;
               else ov = s0_ff.b > s0_ff.a;
            end
            s1_in.fin = 1'b1;
            if (ov) begin
               if (s0_ff.cmd == CMD_SADD || s0_ff.cmd == CMD_SSUB) begin
                  if (!s0_ff.kind[2]) s1_in.r = s0_ff.a[63] ? smin1 : smax1;
                  else s1_in.r = (s0_ff.cmd == CMD_SADD) ? m1 : 64'd0;
               end else begin
                  s1_in.r = '0;
                  s1_in.st = ST_OVF;
               end
            end
         end
         CMD_DIV, CMD_MOD: begin
            if (s0_ff.b == 64'd0) begin
               s1_in.st = ST_DIV0;
               s1_in.fin = 1'b1;
            end else if (!s0_ff.kind[2] && s0_ff.a == smin1 && s0_ff.b == '1) begin
               s1_in.st = ST_OVF;
               s1_in.fin = 1'b1;
            end
         end
         default: ;
      endcase
   end

   logic s1_v_ff;
   ctl_type s1_ff;
   logic [63:0] p_ll_ff, p_lh_ff, p_hl_ff, p_hh_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= s0_v_ff;
      s1_ff <= s1_in;
      p_ll_ff <= p_ll_in;
      p_lh_ff <= p_lh_in;
      p_hl_ff <= p_hl_in;
      p_hh_ff <= p_hh_in;
   end

   // ---------------- divider: restoring, Bps quotient bits per stage
   // stage k holds partial remainder, shifted dividend (quotient shifts in)
   logic [63:0] dv_rem_ff [DIV_STAGES+1];
   logic [63:0] dv_quo_ff [DIV_STAGES+1];
   logic [63:0] dv_den_ff [DIV_STAGES];
   logic [63:0] dv_rem_in [DIV_STAGES];
   logic [63:0] dv_quo_in [DIV_STAGES];

   always_ff @(posedge clock) begin
      dv_rem_ff[0] <= '0;
      dv_quo_ff[0] <= dq_in;
      dv_den_ff[0] <= dr_in;
      for (int k = 0; k < DIV_STAGES; k++) begin
         dv_rem_ff[k+1] <= dv_rem_in[k];
         dv_quo_ff[k+1] <= dv_quo_in[k];
      end
      for (int k = 1; k < DIV_STAGES; k++) dv_den_ff[k] <= dv_den_ff[k-1];
   end

   always_comb begin
      logic [64:0] rr;
      logic [63:0] qq;
      for (int k = 0; k < DIV_STAGES; k++) begin
         rr = {1'b0, dv_rem_ff[k]};
         qq = dv_quo_ff[k];
         for (int j = 0; j < Bps; j++) begin
            rr = {rr[63:0], qq[63]};
            qq = {qq[62:0], 1'b0};
            if (rr >= {1'b0, dv_den_ff[k]}) begin
               rr = rr - {1'b0, dv_den_ff[k]};
               qq[0] = 1'b1;
            end
         end
         dv_rem_in[k] = rr[63:0];
         dv_quo_in[k] = qq;
      end
   end

   // ---------------- stage 2: combine partial products
   logic [63:0] mid2;
   logic [63:0] lo2_in, hi2_in;
   always_comb begin
      mid2 = {32'd0, p_ll_ff[63:32]} + {32'd0, p_lh_ff[31:0]} + {32'd0, p_hl_ff[31:0]};
      lo2_in = {mid2[31:0], p_ll_ff[31:0]};
      hi2_in = p_hh_ff + {32'd0, p_lh_ff[63:32]} + {32'd0, p_hl_ff[63:32]}
         + {32'd0, mid2[63:32]};
      if (!s1_ff.kind[2] && s1_ff.a[63]) hi2_in = hi2_in - s1_ff.b;
      if (!s1_ff.kind[2] && s1_ff.b[63]) hi2_in = hi2_in - s1_ff.a;
   end

   logic s2_v_ff;
   ctl_type s2_ff;
   logic [63:0] lo2_ff, hi2_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
      s2_ff <= s1_ff;
      lo2_ff <= lo2_in;
      hi2_ff <= hi2_in;
   end

   // ---------------- stage 3: multiply results
   ctl_type s3_in;
   logic [63:0] m3;
   logic mov;
   always_comb begin
      s3_in = s2_ff;
      m3 = width_mask(s2_ff.kind);
      if (!s2_ff.kind[2])
         mov = hi2_ff != (lo2_ff[63] ? '1 : 64'd0)
            || load_kind(s2_ff.kind, lo2_ff) != lo2_ff;
      else mov = hi2_ff != 64'd0 || lo2_ff > m3;
      case (s2_ff.cmd)
         CMD_WMUL: begin
            s3_in.r = load_kind(s2_ff.kind, lo2_ff);
            s3_in.fin = 1'b1;
         end
         CMD_MUL, CMD_SMUL: begin
            s3_in.fin = 1'b1;
            s3_in.r = lo2_ff;
            if (mov) begin
               if (s2_ff.cmd == CMD_SMUL)
                  s3_in.r = s2_ff.kind[2] ? m3 : (hi2_ff[63] ? ~(m3 >> 1) : m3 >> 1);
               else begin
                  s3_in.r = '0;
                  s3_in.st = ST_OVF;
               end
            end
         end
         default: ;
      endcase
   end

   // delay line so non-divide requests align with the divider output
   ctl_type dl_ff [Depth];
   logic [Depth-1:0] dl_v_ff;
   always_ff @(posedge clock) begin
      if (reset) dl_v_ff <= '0;
      else dl_v_ff <= {dl_v_ff[Depth-2:0], s2_v_ff};
      dl_ff[0] <= s3_in;
      for (int k = 1; k < Depth; k++) dl_ff[k] <= dl_ff[k-1];
   end

   // divider output lines up with dl_ff[Depth-3] at index DIV_STAGES
   // (divider entered after stage 0, dl_ff[0] after stage 2)
   logic [63:0] q_al_ff, r_al_ff;
   logic [63:0] q_al2_ff, r_al2_ff;
   always_ff @(posedge clock) begin
      q_al_ff <= dv_quo_ff[DIV_STAGES];
      r_al_ff <= dv_rem_ff[DIV_STAGES];
      q_al2_ff <= q_al_ff;
      r_al2_ff <= r_al_ff;
   end

   // ---------------- final stage: sign fix for divide, output register
   ctl_type fe;
   logic [63:0] res_in;
   logic [1:0] st_in;
   logic qneg, rneg;
   always_comb begin
      fe = dl_ff[Depth-1];
      res_in = fe.r;
      st_in = fe.st;
      qneg = !fe.kind[2] && (fe.a[63] ^ fe.b[63]);
      rneg = !fe.kind[2] && fe.a[63];
      if (!fe.fin) begin
         if (fe.cmd == CMD_DIV) res_in = qneg ? 64'd0 - q_al2_ff : q_al2_ff;
         else res_in = rneg ? 64'd0 - r_al2_ff : r_al2_ff;
      end
      if (st_in != ST_OK) res_in = '0;
   end

   logic out_v_ff;
   logic [63:0] out_r_ff;
   logic [1:0] out_st_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else out_v_ff <= dl_v_ff[Depth-1];
      out_r_ff <= res_in;
      out_st_ff <= st_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_result_value = out_r_ff;
   assign rsp_status = out_st_ff;
endmodule
`default_nettype wire
